FILE: hdl/sdrcw_pkg.sv
// Shared types, constants and helpers for the SDR control word decoder.
// No dependencies; every module of the block imports this package.
package sdrcw_pkg;

   // Field widths fixed by the command format
   localparam int BYTE_W   = 8;
   localparam int FREQ_W   = 32;
   localparam int PHASE_W  = 30;
   localparam int RATE_W   = 11;
   localparam int RCV_W    = 4;
   localparam int ACTION_W = 3;
   localparam int CHAN_W   = 3;
   localparam int ATT_W    = 5;
   localparam int ADC_W    = 2;
   localparam int PAIR_W   = 7;

   localparam int NUM_CHANNELS_DEF = 8;

   // Reset values
   localparam logic [PHASE_W-1:0] PHASE_RESET = 30'd5242880;   // 600 kHz
   localparam logic [FREQ_W-1:0]  LIMIT_RESET = 32'd61440000;
   localparam logic [RCV_W-1:0]   RCV_RESET   = 4'd1;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 11'd1280;

   // Result action codes
   localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_GENERAL  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FREQ_SET = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FREQ_REJ = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ATT      = 3'd4;

   // Address pair codes (address byte with bit 0 dropped)
   localparam logic [PAIR_W-1:0] PAIR_GENERAL    = 7'd0;
   localparam logic [PAIR_W-1:0] PAIR_FREQ_LO    = 7'd2;
   localparam logic [PAIR_W-1:0] PAIR_FREQ_HI    = 7'd8;
   localparam logic [PAIR_W-1:0] PAIR_ATT        = 7'd10;
   localparam logic [PAIR_W-1:0] PAIR_FREQ_EXTRA = 7'd18;
   localparam logic [CHAN_W-1:0] CHAN_EXTRA      = 3'd7;

   // Phase increment = floor((f*16384 + 937) / 1875), low 30 bits kept.
   // f = a*1875 + r, so the result is a*16384 + floor((r*16384 + 937) / 1875).
   localparam int DIV_K_W  = 11;
   localparam logic [DIV_K_W-1:0] DIV_K = 11'd1875;
   localparam int QUOT_W   = 22;                       // f / 1875 < 2^22
   localparam int SH1      = 43;                       // 32 + ceil(log2(1875))
   localparam int RECIP1_W = 33;
   localparam logic [RECIP1_W-1:0] RECIP1 =
      33'((64'd8796093022208 + 64'd1874) / 64'd1875); // ceil(2^43 / 1875)
   localparam int NUM2_W   = 25;                       // r*16384 + 937 < 2^25
   localparam logic [NUM2_W-1:0] ROUND_HALF = 25'd937;
   localparam int SH2      = 36;                       // 25 + 11
   localparam int RECIP2_W = 26;
   localparam logic [RECIP2_W-1:0] RECIP2 =
      26'((64'd68719476736 + 64'd1874) / 64'd1875);   // ceil(2^36 / 1875)
   localparam int FRAC_W   = 14;                       // low part < 2^14
   localparam int AHI_W    = PHASE_W - FRAC_W;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_GENERAL,
      CMD_FREQ,
      CMD_ATT
   } cmd_type;

   // Stage load enables handed to the phase divider pipeline
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

   // Decoded command carried alongside the divider pipeline
   typedef struct packed {
      cmd_type           cmd;
      logic [CHAN_W-1:0] chan;
      logic [1:0]        rate_code;
      logic [ADC_W-1:0]  adc;
      logic [2:0]        rcv_m1;
      logic [ATT_W-1:0]  att;
      logic              reject;
   } meta_type;

   function automatic logic [RATE_W-1:0] divider_of(input logic [1:0] code);
      logic [RATE_W-1:0] div;
      unique case (code)
         2'd0:    div = 11'd1280;
         2'd1:    div = 11'd640;
         2'd2:    div = 11'd320;
         default: div = 11'd160;
      endcase
      return div;
   endfunction

endpackage

FILE: hdl/sdr_control_word_decoder_unit.sv
// Top level of the SDR control word decoder: decode, phase store, result register.
// Depends on sdrcw_pkg and sdrcw_phase_div.
//
// Takes one five-byte command transaction per clock while req_stall is low and returns
// exactly one result transaction for each, in order. Throughput is one command per
// cycle while the result side is not stalled, set by the five-stage pipeline: input
// register, two stages of the constant divider, a commit stage that reads and writes
// the phase store (eight entries by default), and the result register. The phase
// store is a synchronous memory read from the stage before commit and registered as
// the command enters commit; a write from the command leaving commit is forwarded to
// a read of the same channel. Each entry has a valid bit cleared by reset, so an
// unwritten channel reads as 600 kHz and no clearing pass is needed. The frequency
// limit register may be written only while no command is in flight.
module sdr_control_word_decoder_unit #(
   parameter int NUM_CHANNELS = sdrcw_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sdrcw_pkg::BYTE_W-1:0]         req_address_byte,
   input  logic [sdrcw_pkg::BYTE_W-1:0]         req_payload_byte1,
   input  logic [sdrcw_pkg::BYTE_W-1:0]         req_payload_byte2,
   input  logic [sdrcw_pkg::BYTE_W-1:0]         req_payload_byte3,
   input  logic [sdrcw_pkg::BYTE_W-1:0]         req_payload_byte4,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sdrcw_pkg::ACTION_W-1:0]       rsp_action,
   output logic [sdrcw_pkg::RCV_W-1:0]          rsp_receiver_count,
   output logic [sdrcw_pkg::RATE_W-1:0]         rsp_rate_divider,
   output logic [sdrcw_pkg::ADC_W-1:0]          rsp_adc_setting,
   output logic                                 rsp_adc_changed,
   output logic [sdrcw_pkg::CHAN_W-1:0]         rsp_channel,
   output logic [sdrcw_pkg::PHASE_W-1:0]        rsp_phase_increment,
   output logic [sdrcw_pkg::ATT_W:0]            rsp_att_drive,
   output logic                                 rsp_att_changed,
   // configuration: frequency limit
   input  logic                                 csr_wr_en,
   input  logic [sdrcw_pkg::FREQ_W-1:0]         csr_wr_data
);
   import sdrcw_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Pipeline occupancy and load enables
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, rsp_valid_ff;
   logic go1, go2, go3, go4, go5;
   logic commit;
   pipe_en_type pipe_en;

   // Decode
   logic [PAIR_W-1:0] pair;
   meta_type          dec_meta;
   logic [CHAN_W-1:0] dec_chan;

   meta_type          s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff;
   logic [FREQ_W-1:0] s1_freq_ff;
   logic [FREQ_W-1:0] limit_ff;

   // Phase store
   logic [PHASE_W-1:0]      phase_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] phase_vld_ff;
   logic [PHASE_W-1:0]      rd_data_ff;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx, wr_idx;
   logic                    fwd;
   logic [PHASE_W-1:0]      div_inc;
   logic [PHASE_W-1:0]      stored_phase;

   // Scalar settings
   logic [RCV_W-1:0]  rcv_ff, rcv_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [ADC_W-1:0]  adc_ff, adc_in;
   logic [ATT_W-1:0]  att_ff, att_in;

   // Commit results
   logic [ACTION_W-1:0] cm_action;
   logic                cm_adc_changed;
   logic                cm_att_changed;
   logic [CHAN_W-1:0]   cm_chan;
   logic [PHASE_W-1:0]  cm_phase;
   logic                cm_write;

   // Result register
   logic [ACTION_W-1:0] rsp_action_ff;
   logic [RCV_W-1:0]    rsp_rcv_ff;
   logic [RATE_W-1:0]   rsp_rate_ff;
   logic [ADC_W-1:0]    rsp_adc_ff;
   logic                rsp_adc_changed_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic [ATT_W-1:0]    rsp_att_ff;
   logic                rsp_att_changed_ff;

   // ------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its content moves on.
   // Bubbles collapse, so a stalled result only blocks once the pipe is full.
   // ------------------------------------------------------------------
   assign go5 = !rsp_valid_ff || !rsp_stall;
   assign go4 = !s4_vld_ff || go5;
   assign go3 = !s3_vld_ff || go4;
   assign go2 = !s2_vld_ff || go3;
   assign go1 = !s1_vld_ff || go2;

   assign req_stall = !go1;
   assign commit    = s4_vld_ff && go5;

   assign pipe_en.s2 = go2;
   assign pipe_en.s3 = go3;
   assign pipe_en.s4 = go4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go1) s1_vld_ff    <= req_valid;
         if (go2) s2_vld_ff    <= s1_vld_ff;
         if (go3) s3_vld_ff    <= s2_vld_ff;
         if (go4) s4_vld_ff    <= s3_vld_ff;
         if (go5) rsp_valid_ff <= s4_vld_ff;
      end
   end

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Address decode: drop bit 0, map pairs to a command kind and channel
   // ------------------------------------------------------------------
   assign pair = req_address_byte[BYTE_W-1:1];

   always_comb begin
      dec_chan = '0;
      dec_meta = '0;
      dec_meta.cmd = CMD_NONE;
      unique case (pair) inside
         PAIR_GENERAL: begin
            dec_meta.cmd = CMD_GENERAL;
         end
         PAIR_ATT: begin
            dec_meta.cmd = CMD_ATT;
         end
         [PAIR_FREQ_LO:PAIR_FREQ_HI]: begin
            dec_meta.cmd = CMD_FREQ;
            dec_chan     = CHAN_W'(pair - PAIR_FREQ_LO);
         end
         PAIR_FREQ_EXTRA: begin
            dec_meta.cmd = CMD_FREQ;
            dec_chan     = CHAN_EXTRA;
         end
         default: begin
            dec_meta.cmd = CMD_NONE;
         end
      endcase
      // drop channels this build does not have
      if (dec_meta.cmd == CMD_FREQ && 32'(dec_chan) >= NUM_CHANNELS) begin
         dec_meta.cmd = CMD_NONE;
         dec_chan     = '0;
      end
      dec_meta.chan      = dec_chan;
      dec_meta.rate_code = req_payload_byte1[1:0];
      dec_meta.adc       = req_payload_byte3[3:2];
      dec_meta.rcv_m1    = req_payload_byte4[5:3];
      dec_meta.att       = req_payload_byte4[ATT_W-1:0];
      // the user is to hold the limit steady while commands are in flight; the block does not enforce it
      dec_meta.reject    = {req_payload_byte1, req_payload_byte2,
                            req_payload_byte3, req_payload_byte4} > limit_ff;
   end

   // ------------------------------------------------------------------
   // Command pipeline: decoded fields ride along with the divider stages
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (go1) begin
         s1_meta_ff <= dec_meta;
         s1_freq_ff <= {req_payload_byte1, req_payload_byte2,
                        req_payload_byte3, req_payload_byte4};
      end
      if (go2) s2_meta_ff <= s1_meta_ff;
      if (go3) s3_meta_ff <= s2_meta_ff;
      if (go4) s4_meta_ff <= s3_meta_ff;
   end

   sdrcw_phase_div u_phase_div (
      .clock (clock),
      .en    (pipe_en),
      .freq  (s1_freq_ff),
      .inc   (div_inc)
   );

   // ------------------------------------------------------------------
   // Phase store: read ahead of commit, write at commit, forward on a hit
   // ------------------------------------------------------------------
   assign rd_idx = s3_meta_ff.chan[IDX_W-1:0];
   assign wr_idx = s4_meta_ff.chan[IDX_W-1:0];
   assign fwd    = commit && cm_write && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (commit && cm_write) begin
         phase_mem[wr_idx] <= div_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (go4) begin
         if (fwd) begin
            rd_data_ff <= div_inc;
            rd_vld_ff  <= 1'b1;
         end else begin
            rd_data_ff <= phase_mem[rd_idx];
            rd_vld_ff  <= phase_vld_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_vld_ff <= '0;
      end else if (commit && cm_write) begin
         phase_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // an entry never written holds the 600 kHz default
   assign stored_phase = rd_vld_ff ? rd_data_ff : PHASE_RESET;

   // ------------------------------------------------------------------
   // Commit: apply the command to the settings and form the result
   // ------------------------------------------------------------------
   always_comb begin
      rcv_in         = rcv_ff;
      rate_in        = rate_ff;
      adc_in         = adc_ff;
      att_in         = att_ff;
      cm_action      = ACT_NONE;
      cm_adc_changed = 1'b0;
      cm_att_changed = 1'b0;
      cm_chan        = '0;
      cm_phase       = '0;
      cm_write       = 1'b0;
      unique case (s4_meta_ff.cmd)
         CMD_GENERAL: begin
            cm_action      = ACT_GENERAL;
            rcv_in         = {1'b0, s4_meta_ff.rcv_m1} + RCV_W'(1);
            rate_in        = divider_of(s4_meta_ff.rate_code);
            adc_in         = s4_meta_ff.adc;
            cm_adc_changed = s4_meta_ff.adc != adc_ff;
         end
         CMD_ATT: begin
            cm_action      = ACT_ATT;
            att_in         = s4_meta_ff.att;
            cm_att_changed = s4_meta_ff.att != att_ff;
         end
         CMD_FREQ: begin
            cm_chan = s4_meta_ff.chan;
            if (s4_meta_ff.reject) begin
               cm_action = ACT_FREQ_REJ;
               cm_phase  = stored_phase;
            end else begin
               cm_action = ACT_FREQ_SET;
               cm_phase  = div_inc;
               cm_write  = 1'b1;
            end
         end
         default: begin
            cm_action = ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff  <= RCV_RESET;
         rate_ff <= RATE_RESET;
         adc_ff  <= '0;
         att_ff  <= '0;
      end else if (commit) begin
         rcv_ff  <= rcv_in;
         rate_ff <= rate_in;
         adc_ff  <= adc_in;
         att_ff  <= att_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: hold while stalled, load as the commit stage drains
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (go5) begin
         rsp_action_ff      <= cm_action;
         rsp_rcv_ff         <= rcv_in;
         rsp_rate_ff        <= rate_in;
         rsp_adc_ff         <= adc_in;
         rsp_adc_changed_ff <= cm_adc_changed;
         rsp_chan_ff        <= cm_chan;
         rsp_phase_ff       <= cm_phase;
         rsp_att_ff         <= att_in;
         rsp_att_changed_ff <= cm_att_changed;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_receiver_count  = rsp_rcv_ff;
   assign rsp_rate_divider    = rsp_rate_ff;
   assign rsp_adc_setting     = rsp_adc_ff;
   assign rsp_adc_changed     = rsp_adc_changed_ff;
   assign rsp_channel         = rsp_chan_ff;
   assign rsp_phase_increment = rsp_phase_ff;
   assign rsp_att_drive       = {rsp_att_ff, 1'b0};
   assign rsp_att_changed     = rsp_att_changed_ff;

endmodule

FILE: hdl/sdrcw_phase_div.sv
// Pipelined frequency-to-phase-increment converter (division by a constant).
// Depends on sdrcw_pkg; stage loads are driven by the top level.
module sdrcw_phase_div (
   input  logic                                clock,
   input  sdrcw_pkg::pipe_en_type              en,
   input  logic [sdrcw_pkg::FREQ_W-1:0]        freq,
   output logic [sdrcw_pkg::PHASE_W-1:0]       inc
);
   import sdrcw_pkg::*;

   localparam int P1_W = FREQ_W + RECIP1_W;
   localparam int P2_W = NUM2_W + RECIP2_W;

   logic [P1_W-1:0]      prod1;
   logic [QUOT_W-1:0]    quot_ff;
   logic [DIV_K_W-1:0]   flo_ff;
   logic [2*DIV_K_W-1:0] back_mul;
   logic [DIV_K_W-1:0]   rem_ff;
   logic [AHI_W-1:0]     ahi3_ff;
   logic [NUM2_W-1:0]    num2;
   logic [P2_W-1:0]      prod2;
   logic [FRAC_W-1:0]    frac_ff;
   logic [AHI_W-1:0]     ahi4_ff;

   // Stage 2: coarse quotient f / 1875 by reciprocal multiply
   assign prod1 = {{RECIP1_W{1'b0}}, freq} * {{FREQ_W{1'b0}}, RECIP1};

   always_ff @(posedge clock) begin
      if (en.s2) begin
         quot_ff <= prod1[SH1 +: QUOT_W];
         flo_ff  <= freq[DIV_K_W-1:0];
      end
   end

   // Stage 3: remainder, exact modulo 2^11 since it stays below 1875
   assign back_mul = quot_ff[DIV_K_W-1:0] * DIV_K;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         rem_ff  <= flo_ff - back_mul[DIV_K_W-1:0];
         ahi3_ff <= quot_ff[AHI_W-1:0];
      end
   end

   // Stage 4: fine quotient of the scaled and rounded remainder
   assign num2  = {rem_ff, {FRAC_W{1'b0}}} + ROUND_HALF;
   assign prod2 = {{RECIP2_W{1'b0}}, num2} * {{NUM2_W{1'b0}}, RECIP2};

   always_ff @(posedge clock) begin
      if (en.s4) begin
         frac_ff <= prod2[SH2 +: FRAC_W];
         ahi4_ff <= ahi3_ff;
      end
   end

   assign inc = {ahi4_ff, frac_ff};

endmodule

FILE: dv/sdrcw_decode_checker.sv
// Checker for the SDR control word decoder: predicts and compares result transactions.
// Depends on sdrcw_pkg; instantiated beside the block by tb_sdr_control_word_decoder_unit.
module sdrcw_decode_checker #(
   parameter int NUM_CHANNELS = sdrcw_pkg::NUM_CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [sdrcw_pkg::BYTE_W-1:0]   req_address_byte,
   input  logic [sdrcw_pkg::BYTE_W-1:0]   req_payload_byte1,
   input  logic [sdrcw_pkg::BYTE_W-1:0]   req_payload_byte2,
   input  logic [sdrcw_pkg::BYTE_W-1:0]   req_payload_byte3,
   input  logic [sdrcw_pkg::BYTE_W-1:0]   req_payload_byte4,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [sdrcw_pkg::ACTION_W-1:0] rsp_action,
   input  logic [sdrcw_pkg::RCV_W-1:0]    rsp_receiver_count,
   input  logic [sdrcw_pkg::RATE_W-1:0]   rsp_rate_divider,
   input  logic [sdrcw_pkg::ADC_W-1:0]    rsp_adc_setting,
   input  logic                           rsp_adc_changed,
   input  logic [sdrcw_pkg::CHAN_W-1:0]   rsp_channel,
   input  logic [sdrcw_pkg::PHASE_W-1:0]  rsp_phase_increment,
   input  logic [sdrcw_pkg::ATT_W:0]      rsp_att_drive,
   input  logic                           rsp_att_changed,
   input  logic                           csr_wr_en,
   input  logic [sdrcw_pkg::FREQ_W-1:0]   csr_wr_data,
   output int                             fail_count,
   output int                             outstanding
);
   import sdrcw_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [RCV_W-1:0]    rcv_count;
      logic [RATE_W-1:0]   rate_div;
      logic [ADC_W-1:0]    adc;
      logic                adc_chg;
      logic [CHAN_W-1:0]   chan;
      logic [PHASE_W-1:0]  phase;
      logic [ATT_W:0]      att_drive;
      logic                att_chg;
   } decode_result_type;

   localparam logic [RATE_W-1:0] RATE_BY_CODE [4] = '{11'd1280, 11'd640, 11'd320, 11'd160};
   localparam logic [63:0] PHASE_SCALE = 64'd32768;
   localparam logic [63:0] PHASE_ROUND = 64'd1875;
   localparam logic [63:0] PHASE_DIV   = 64'd3750;
   localparam int          REPORT_MAX  = 10;

   // Shadow copy of the block's state and its limit register
   logic [FREQ_W-1:0]  freq_limit;
   logic [RCV_W-1:0]   rcv_count;
   logic [RATE_W-1:0]  rate_div;
   logic [ADC_W-1:0]   adc_last;
   logic [ATT_W-1:0]   att_last;
   logic [PHASE_W-1:0] phase_store [8];

   decode_result_type decoded_q [$];
   int                errors = 0;

   function automatic string fmt_result(input decode_result_type r);
      return $sformatf("act=%0d rcv=%0d rate=%0d adc=%0d/%0b ch=%0d ph=%0d att=%0d/%0b",
                       r.action, r.rcv_count, r.rate_div, r.adc, r.adc_chg, r.chan,
                       r.phase, r.att_drive, r.att_chg);
   endfunction

   // Apply one command block to the shadow state and return its result
   function automatic decode_result_type decode_command(input logic [BYTE_W-1:0] addr, b1,
                                                        b2, b3, b4);
      decode_result_type r;
      logic [PAIR_W-1:0] pair;
      logic [FREQ_W-1:0] freq;
      logic [63:0]       num;
      logic [ADC_W-1:0]  adc;
      logic [ATT_W-1:0]  att;
      int                ch;
      r    = '0;
      pair = addr[BYTE_W-1:1];
      freq = {b1, b2, b3, b4};
      adc  = b3[3:2];
      att  = b4[ATT_W-1:0];
      ch   = -1;
      if (pair >= PAIR_FREQ_LO && pair <= PAIR_FREQ_HI) begin
         ch = int'(pair - PAIR_FREQ_LO);
      end else if (pair == PAIR_FREQ_EXTRA) begin
         ch = int'(CHAN_EXTRA);
      end
      if (pair == PAIR_GENERAL) begin
         r.action  = ACT_GENERAL;
         rcv_count = {1'b0, b4[5:3]} + 4'd1;
         if (adc != adc_last) begin
            adc_last  = adc;
            r.adc_chg = 1'b1;
         end
         rate_div = RATE_BY_CODE[b1[1:0]];
      end else if (pair == PAIR_ATT) begin
         r.action = ACT_ATT;
         if (att != att_last) begin
            att_last  = att;
            r.att_chg = 1'b1;
         end
      end else if (ch >= 0 && ch < NUM_CHANNELS) begin
         r.chan = CHAN_W'(ch);
         if (freq > freq_limit) begin
            r.action = ACT_FREQ_REJ;
         end else begin
            num             = 64'(freq) * PHASE_SCALE + PHASE_ROUND;
            phase_store[ch] = PHASE_W'(num / PHASE_DIV);
            r.action        = ACT_FREQ_SET;
         end
         r.phase = phase_store[ch];
      end
      r.rcv_count = rcv_count;
      r.rate_div  = rate_div;
      r.adc       = adc_last;
      r.att_drive = {att_last, 1'b0};
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      decode_result_type got;
      decode_result_type want;
      if (reset) begin
         freq_limit = LIMIT_RESET;
         rcv_count  = RCV_RESET;
         rate_div   = RATE_RESET;
         adc_last   = '0;
         att_last   = '0;
         foreach (phase_store[i]) phase_store[i] = PHASE_RESET;
         decoded_q.delete();
      end else begin
         if (csr_wr_en) freq_limit = csr_wr_data;
         // Retire the oldest expectation before adding a new one
         if (rsp_valid && !rsp_stall) begin
            got.action    = rsp_action;
            got.rcv_count = rsp_receiver_count;
            got.rate_div  = rsp_rate_divider;
            got.adc       = rsp_adc_setting;
            got.adc_chg   = rsp_adc_changed;
            got.chan      = rsp_channel;
            got.phase     = rsp_phase_increment;
            got.att_drive = rsp_att_drive;
            got.att_chg   = rsp_att_changed;
            if (decoded_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("unexpected result: %s", fmt_result(got));
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("mismatch exp: %s", fmt_result(want));
                     $display("mismatch got: %s", fmt_result(got));
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            decoded_q.push_back(decode_command(req_address_byte, req_payload_byte1,
                                               req_payload_byte2, req_payload_byte3,
                                               req_payload_byte4));
      end
      outstanding <= decoded_q.size();
      fail_count  <= errors;
   end

endmodule

FILE: dv/tb_sdr_control_word_decoder_unit.sv
// Testbench top for the SDR control word decoder: clock, reset, stimulus and verdict.
// Depends on sdrcw_pkg, sdr_control_word_decoder_unit and sdrcw_decode_checker.
module tb_sdr_control_word_decoder_unit;
   import sdrcw_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;   // quiet cycles before the run is declared hung
   localparam int SETTLE_CYCLES   = 8;      // pipeline is five deep, allow a few extra
   localparam int ITEMS_PER_PHASE = 290;
   localparam int NUM_PHASES      = 6;
   // Limit settings walked through after the directed part; a random one follows as the last
   localparam logic [FREQ_W-1:0] LIMIT_PLAN [NUM_PHASES-1] =
      '{32'd0, 32'hFFFF_FFFF, 32'd61440000, 32'd200000000, 32'd1};
   // Address pairs that carry no command
   localparam logic [PAIR_W-1:0] UNUSED_PAIRS [5] = '{7'd1, 7'd9, 7'd11, 7'd19, 7'd127};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_address_byte  = '0;
   logic [BYTE_W-1:0]   req_payload_byte1 = '0;
   logic [BYTE_W-1:0]   req_payload_byte2 = '0;
   logic [BYTE_W-1:0]   req_payload_byte3 = '0;
   logic [BYTE_W-1:0]   req_payload_byte4 = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ACTION_W-1:0] rsp_action;
   logic [RCV_W-1:0]    rsp_receiver_count;
   logic [RATE_W-1:0]   rsp_rate_divider;
   logic [ADC_W-1:0]    rsp_adc_setting;
   logic                rsp_adc_changed;
   logic [CHAN_W-1:0]   rsp_channel;
   logic [PHASE_W-1:0]  rsp_phase_increment;
   logic [ATT_W:0]      rsp_att_drive;
   logic                rsp_att_changed;
   logic                csr_wr_en = 1'b0;
   logic [FREQ_W-1:0]   csr_wr_data = '0;

   int                  fail_count;
   int                  outstanding;
   logic [FREQ_W-1:0]   cur_limit = LIMIT_RESET;   // limit the block holds right now
   int                  burst_left = 0;
   int                  quiet_cycles = 0;

   // Receiver stall pattern state
   int                  stall_mode = 0;
   int                  stall_span = 0;
   logic [15:0]         stall_mask = 16'h0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sdr_control_word_decoder_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_address_byte    (req_address_byte),
      .req_payload_byte1   (req_payload_byte1),
      .req_payload_byte2   (req_payload_byte2),
      .req_payload_byte3   (req_payload_byte3),
      .req_payload_byte4   (req_payload_byte4),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_receiver_count  (rsp_receiver_count),
      .rsp_rate_divider    (rsp_rate_divider),
      .rsp_adc_setting     (rsp_adc_setting),
      .rsp_adc_changed     (rsp_adc_changed),
      .rsp_channel         (rsp_channel),
      .rsp_phase_increment (rsp_phase_increment),
      .rsp_att_drive       (rsp_att_drive),
      .rsp_att_changed     (rsp_att_changed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   sdrcw_decode_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_address_byte    (req_address_byte),
      .req_payload_byte1   (req_payload_byte1),
      .req_payload_byte2   (req_payload_byte2),
      .req_payload_byte3   (req_payload_byte3),
      .req_payload_byte4   (req_payload_byte4),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_receiver_count  (rsp_receiver_count),
      .rsp_rate_divider    (rsp_rate_divider),
      .rsp_adc_setting     (rsp_adc_setting),
      .rsp_adc_changed     (rsp_adc_changed),
      .rsp_channel         (rsp_channel),
      .rsp_phase_increment (rsp_phase_increment),
      .rsp_att_drive       (rsp_att_drive),
      .rsp_att_changed     (rsp_att_changed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // Receiver side: switch between no stall, random stall, a rotating pattern and heavy
   // stall, each held for a random span so stalls land on every pipeline state.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 300);
         stall_mask <= 16'($urandom);
         rsp_stall  <= 1'b0;
      end else begin
         stall_span <= stall_span - 1;
         stall_mask <= {stall_mask[14:0], stall_mask[15]};
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 99) < 35);
            end
            2: begin
               rsp_stall <= stall_mask[15];
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 9) < 8);
            end
         endcase
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] addr_of(input logic [PAIR_W-1:0] pair,
                                                 input logic odd);
      return {pair, odd};
   endfunction

   // Present one command and hold it until the block takes it. Within a burst it returns at the
   // accepting edge with valid still high, so the burst continues without a bubble.
   task automatic push_cmd(input logic [BYTE_W-1:0] addr, b1, b2, b3, b4);
      int gap;
      req_valid         <= 1'b1;
      req_address_byte  <= addr;
      req_payload_byte1 <= b1;
      req_payload_byte2 <= b2;
      req_payload_byte3 <= b3;
      req_payload_byte4 <= b4;
      do @(posedge clock); while (req_stall);
      // Close the burst with a random gap, which may be empty, then pick the length of the next one
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                 : $urandom_range(50, 200);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic push_freq(input logic [BYTE_W-1:0] addr, input logic [FREQ_W-1:0] freq);
      push_cmd(addr, freq[31:24], freq[23:16], freq[15:8], freq[7:0]);
   endtask

   // Drop valid, wait for every result and let the pipeline go quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [FREQ_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_limit    = value;
   endtask

   // One random command: mostly well-formed commands with random content, the
   // frequency picked around the current limit so both sides of it are hit.
   task automatic push_random_cmd();
      int                sel;
      int                pick;
      logic [PAIR_W-1:0] pair;
      logic [FREQ_W-1:0] freq;
      logic [BYTE_W-1:0] att_byte;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         push_cmd(addr_of(PAIR_GENERAL, 1'($urandom)), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
      end else if (sel < 40) begin
         // Small codes repeat often, so the unchanged case shows up
         att_byte = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         push_cmd(addr_of(PAIR_ATT, 1'($urandom)), 8'($urandom), 8'($urandom),
                  8'($urandom), att_byte);
      end else if (sel < 90) begin
         pick = $urandom_range(0, 7);
         pair = (pick < 7) ? PAIR_FREQ_LO + PAIR_W'(pick) : PAIR_FREQ_EXTRA;
         case ($urandom_range(0, 5))
            0, 1:    freq = $urandom_range(0, cur_limit);
            2:       freq = cur_limit;
            3:       freq = cur_limit + 32'd1;
            4:       freq = cur_limit + 32'($urandom_range(0, 8)) - 32'd4;
            default: freq = $urandom();
         endcase
         push_freq(addr_of(pair, 1'($urandom)), freq);
      end else begin
         push_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset limit
      push_freq(addr_of(PAIR_FREQ_LO, 1'b0), 32'd0);                 // lowest frequency
      push_freq(addr_of(PAIR_FREQ_LO, 1'b1), LIMIT_RESET);           // exactly at the limit
      push_freq(addr_of(PAIR_FREQ_LO + 7'd1, 1'b0), LIMIT_RESET + 32'd1); // just above
      push_freq(addr_of(PAIR_FREQ_HI, 1'b1), 32'hFFFF_FFFF);         // far above, untouched
      push_freq(addr_of(PAIR_FREQ_EXTRA, 1'b0), 32'd600000);         // extra channel pair
      push_freq(addr_of(PAIR_FREQ_EXTRA, 1'b1), 32'd14074000);
      push_freq(addr_of(PAIR_FREQ_HI, 1'b0), 32'd1);
      push_freq(addr_of(PAIR_FREQ_LO + 7'd2, 1'b0), 32'h0000_00FF);
      push_cmd(addr_of(PAIR_GENERAL, 1'b0), 8'h00, 8'h00, 8'h0C, 8'h38); // ADC changes
      push_cmd(addr_of(PAIR_GENERAL, 1'b1), 8'h01, 8'hFF, 8'hFF, 8'h00); // ADC same
      push_cmd(addr_of(PAIR_GENERAL, 1'b0), 8'h02, 8'h00, 8'h00, 8'h07);
      push_cmd(addr_of(PAIR_GENERAL, 1'b1), 8'hFF, 8'hFF, 8'hF3, 8'hFF);
      push_cmd(addr_of(PAIR_ATT, 1'b0), 8'h00, 8'h00, 8'h00, 8'h1F);     // attenuation max
      push_cmd(addr_of(PAIR_ATT, 1'b1), 8'hFF, 8'hFF, 8'hFF, 8'hFF);     // same code
      push_cmd(addr_of(PAIR_ATT, 1'b0), 8'h00, 8'h00, 8'h00, 8'h00);
      push_cmd(addr_of(PAIR_ATT, 1'b1), 8'h00, 8'h00, 8'h00, 8'hE0);     // upper bits ignored
      foreach (UNUSED_PAIRS[i])
         push_cmd(addr_of(UNUSED_PAIRS[i], 1'(i)), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drain();

      // Random part: walk the limit through its extremes and a few values between
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit((p < NUM_PHASES - 1) ? LIMIT_PLAN[p] : 32'($urandom));
         repeat (ITEMS_PER_PHASE) push_random_cmd();
         drain();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/sdrcw_pkg.sv
hdl/sdrcw_phase_div.sv
hdl/sdr_control_word_decoder_unit.sv
dv/sdrcw_decode_checker.sv
dv/tb_sdr_control_word_decoder_unit.sv
